// File: hdl/pba_pkg.sv
// Shared types, codes and helpers for the page bitmap allocator.
package pba_pkg;

   // Fixed field widths
   localparam int ADDR_W    = 32;
   localparam int OP_W      = 2;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int BYTES_W   = 8;

   // Parameter defaults
   localparam int MAP_BYTES_DEF  = 128;
   localparam int PAGE_BYTES_DEF = 4096;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_ANY     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES = 1'd1;

   // Status codes
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FAIL = 1'b1;

   localparam logic [7:0] FULL_BYTE = 8'hFF;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] request_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] page_address;
      logic              status;
   } rsp_type;

   // Page lookup result: in range, bit within byte, page start
   typedef struct packed {
      logic              hit;
      logic [2:0]        bit_sel;
      logic [ADDR_W-1:0] start;
   } loc_type;

   // Mask for page j of a byte, MSB first
   function automatic logic [7:0] bit_mask(input logic [2:0] sel);
      bit_mask = 8'h80 >> sel;
   endfunction

   // Lowest page number with its bit set, MSB first
   function automatic logic [2:0] first_free(input logic [7:0] b);
      logic [2:0] r;
      r = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (b[7-j]) r = 3'(j);
      end
      first_free = r;
   endfunction

endpackage

// File: hdl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/pba_locate.sv
// Page lookup for named requests: align, range check, map to byte and bit.
module pba_locate #(
   parameter int MAP_BYTES  = 128,
   parameter int PAGE_BYTES = 4096,
   parameter int IDX_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1,
   parameter int CNT_W      = $clog2(MAP_BYTES + 1)
) (
   input  logic [pba_pkg::ADDR_W-1:0] addr,
   input  logic [pba_pkg::ADDR_W-1:0] base,
   input  logic [CNT_W-1:0]           used,
   output pba_pkg::loc_type           loc,
   output logic [IDX_W-1:0]           idx
);
   import pba_pkg::*;

   localparam int PG_SH = $clog2(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] PG_MASK = ~(ADDR_W'(PAGE_BYTES - 1));

   logic [ADDR_W-1:0] aligned;
   logic [ADDR_W+1:0] limit;
   logic [ADDR_W-1:0] offset;

   // Truncate to page and check [base, base + used*8 pages) in wide math
   always_comb begin
      aligned = addr & PG_MASK;
      limit   = {2'b00, base} + ((ADDR_W+2)'(used) << (PG_SH + 3));
      offset  = aligned - base;
      loc.hit     = (aligned >= base) && ({2'b00, aligned} < limit);
      loc.bit_sel = offset[PG_SH+2:PG_SH];
      loc.start   = aligned;
      idx         = IDX_W'(offset >> (PG_SH + 3));
   end

endmodule

// File: hdl/page_bitmap_allocator_core.sv
// Page bitmap allocator top level: config, sequencer and free-map RAM.
//
//  channel  ports                               handshake
//  -------  ----------------------------------  ------------------------------
//  request  start, busy, req_data               beat taken when start & !busy
//  result   rsp_strobe, rsp_data                one-cycle strobe, no back-pressure
//  config   csr_we, csr_index, csr_wdata        write taken when csr_we
//
// Named allocate/release: lookup, RAM read, write back; an out-of-range address ends after the lookup.
// Allocate-any: one RAM read per byte scanned.
// Mark-all-free: one RAM write per byte in use, then the result beat.
// After reset all MAP_BYTES bytes of the free map are swept to all ones, with busy high.
// busy is low only in idle; results are never held off.
module page_bitmap_allocator_core #(
   parameter int MAP_BYTES  = pba_pkg::MAP_BYTES_DEF,
   parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pba_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output pba_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [pba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pba_pkg::CSR_W-1:0]     csr_wdata
);
   import pba_pkg::*;

   localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_W = $clog2(MAP_BYTES + 1);
   localparam int PG_SH = $clog2(PAGE_BYTES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FILL = 3'd1;
   localparam logic [2:0] S_LOOK = 3'd2;
   localparam logic [2:0] S_MOD  = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;

   // Config registers
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   // Sequencer state
   logic [2:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic              init_ff, init_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   loc_type           loc_ff, loc_in;
   logic [IDX_W-1:0]  lidx_ff, lidx_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   // RAM port signals
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [7:0]       ram_rdata;

   // Lookup and scan helpers
   logic [15:0]       bytes_ext;
   logic [15:0]       used_ext;
   logic [CNT_W-1:0]  used;
   loc_type           loc;
   logic [IDX_W-1:0]  loc_idx;
   logic [2:0]        scan_bit;
   logic [ADDR_W:0]   scan_addr;
   logic [7:0]        lmask;

   pba_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES),
      .AW    (IDX_W)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pba_locate #(
      .MAP_BYTES  (MAP_BYTES),
      .PAGE_BYTES (PAGE_BYTES),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_locate (
      .addr (addr_ff),
      .base (base_ff),
      .used (used),
      .loc  (loc),
      .idx  (loc_idx)
   );

   // Bytes in use, clamped to the map size
   always_comb begin
      bytes_ext = 16'(bytes_ff);
      used_ext  = (bytes_ext > 16'(MAP_BYTES)) ? 16'(MAP_BYTES) : bytes_ext;
      used      = used_ext[CNT_W-1:0];
   end

   // Scan: first free page in the byte just read and its address
   always_comb begin
      scan_bit  = first_free(ram_rdata);
      scan_addr = {1'b0, base_ff} + ((ADDR_W+1)'({pidx_ff, scan_bit}) << PG_SH);
      lmask     = bit_mask(loc_ff.bit_sel);
   end

   // Config writes
   always_comb begin
      base_in  = base_ff;
      bytes_in = bytes_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BASE:  base_in  = csr_wdata;
            REG_BYTES: bytes_in = csr_wdata[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      init_in       = init_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      loc_in        = loc_ff;
      lidx_in       = lidx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff[IDX_W-1:0];
      ram_wdata     = FULL_BYTE;
      ram_raddr     = ptr_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_data.opcode;
               addr_in = req_data.request_address;
               ptr_in  = '0;
               end_in  = used;
               rsp_in  = '{page_address: '0, status: STAT_OK};
               case (req_data.opcode)
                  OP_CLEAR: begin
                     if (used == '0) rsp_strobe_in = 1'b1;
                     else            state_in      = S_FILL;
                  end
                  OP_ALLOC, OP_RELEASE: state_in = S_LOOK;
                  OP_ANY: begin
                     if (used == '0) begin
                        rsp_in.status = STAT_FAIL;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Write all ones over [0, end)
         S_FILL: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_in == end_ff) begin
               state_in = S_IDLE;
               init_in  = 1'b0;
               if (!init_ff) begin
                  rsp_in        = '{page_address: '0, status: STAT_OK};
                  rsp_strobe_in = 1'b1;
               end
            end
         end

         // Range check, issue the byte read
         S_LOOK: begin
            loc_in    = loc;
            lidx_in   = loc_idx;
            ram_raddr = loc_idx;
            if (loc.hit) begin
               state_in = S_MOD;
            end else begin
               state_in      = S_IDLE;
               rsp_in        = '{page_address: '0,
                                 status: (op_ff == OP_ALLOC) ? STAT_FAIL : STAT_OK};
               rsp_strobe_in = 1'b1;
            end
         end

         // Read-modify-write of the named byte
         S_MOD: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            ram_waddr     = lidx_ff;
            if (op_ff == OP_ALLOC) begin
               ram_wdata = ram_rdata & ~lmask;
               if ((ram_rdata & lmask) != 8'h00) begin
                  ram_we = 1'b1;
                  rsp_in = '{page_address: loc_ff.start, status: STAT_OK};
               end else begin
                  rsp_in = '{page_address: '0, status: STAT_FAIL};
               end
            end else begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata | lmask;
               rsp_in    = '{page_address: '0, status: STAT_OK};
            end
         end

         // One byte read per cycle; check the byte read last cycle
         S_SCAN: begin
            if (ptr_ff != end_ff) begin
               pend_in = 1'b1;
               pidx_in = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + 1'b1;
            end
            if (pend_ff && ram_rdata != 8'h00) begin
               pend_in       = 1'b0;
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               if (!scan_addr[ADDR_W]) begin
                  ram_we    = 1'b1;
                  ram_waddr = pidx_ff;
                  ram_wdata = ram_rdata & ~bit_mask(scan_bit);
                  rsp_in    = '{page_address: scan_addr[ADDR_W-1:0], status: STAT_OK};
               end else begin
                  rsp_in = '{page_address: '0, status: STAT_FAIL};
               end
            end else if (ptr_ff == end_ff && (pend_ff || end_ff == '0)) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in        = '{page_address: '0, status: STAT_FAIL};
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         init_ff       <= 1'b1;
         ptr_ff        <= '0;
         end_ff        <= CNT_W'(MAP_BYTES);
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         base_ff       <= '0;
         bytes_ff      <= BYTES_W'(128);
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         ptr_ff        <= ptr_in;
         end_ff        <= end_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         base_ff       <= base_in;
         bytes_ff      <= bytes_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      addr_ff <= addr_in;
      pidx_ff <= pidx_in;
      loc_ff  <= loc_in;
      lidx_ff <= lidx_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
